// ===== src/skv_pkg.sv =====
// Shared types and codes for the sorted key/value list unit.
// No dependencies; imported by every module of the block but skv_bound_enc.
`timescale 1ns / 1ps

package skv_pkg;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_GET      = 3'd2,
    OP_SET      = 3'd3,
    OP_CONTAINS = 3'd4,
    OP_INDEX    = 3'd5,
    OP_SIZE     = 3'd6
  } skv_op_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic [7:0]         pos;
  } skv_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] key_out;
    logic signed [31:0] value_out;
    logic               found;
    logic [7:0]         first_match_res;
    logic [8:0]         match_count;
    logic [8:0]         entry_total;
  } skv_out_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] value;
  } skv_entry_t;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_DELETE = 2'd2
  } skv_cell_mode_t;

  typedef struct packed {
    skv_cell_mode_t mode;
    logic           vld;
    logic           at_end;
    logic           from_pos;
  } skv_cell_ctl_t;

endpackage

// ===== src/sorted_key_value_list_unit.sv =====
// Sorted key/value list: an item is worked in state S_RUN by the row of
// compare-and-shift cells (set: a shift left in S_RUN, then a shift right
// in S_INS), the result being registered and shown in the cycle after the
// last such state. busy is high while the cell row works; start is taken
// whenever busy is low, also in the cycle that shows the previous result.
// Each result is shown for exactly one cycle with out_valid and is not held.
// The list is empty after reset. Depends on skv_pkg, skv_cell, skv_bound_enc.
`timescale 1ns / 1ps

module sorted_key_value_list_unit #(
  parameter int CAPACITY = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  skv_pkg::skv_in_t  in_item,
  output logic              out_valid,
  output skv_pkg::skv_out_t out_item
);
  import skv_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_INS  = 3'b100
  } skv_state_t;

  skv_state_t     state_r, state_nxt;
  skv_in_t        cmd_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic           out_valid_r, out_valid_nxt;
  skv_out_t       out_r, out_nxt;
  skv_cell_mode_t mode;

  skv_entry_t     new_entry;
  skv_entry_t     entries [CAPACITY];
  logic [CAPACITY-1:0] p_vec;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] le_vec;
  logic [CAPACITY+1:0] lt_ext;
  logic [CAPACITY+1:0] le_ext;
  logic [CW-1:0]  lt_idx, le_idx, run_len;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic           pos_ok;
  logic [63:0]    rd_bits;

  assign new_entry = '{key: cmd_r.key, value: cmd_r.value};
  assign pos_ext   = CMPW'(cmd_r.pos);
  assign cnt_ext   = CMPW'(count_r);
  assign pos_ok    = pos_ext < cnt_ext;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skv_cell_ctl_t ctl;
    skv_entry_t    left_e, right_e;
    logic          p_l;

    assign ctl.mode     = mode;
    assign ctl.vld      = CMPW'(i) < cnt_ext;
    assign ctl.at_end   = CMPW'(i) == cnt_ext;
    assign ctl.from_pos = CMPW'(i) >= pos_ext;

    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign p_l    = 1'b0;
    end else begin : g_inner
      assign left_e = entries[i-1];
      assign p_l    = p_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_body
      assign right_e = entries[i+1];
    end

    skv_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .cmp_key     (cmd_r.key),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .p_left      (p_l),
      .entry       (entries[i]),
      .p           (p_vec[i]),
      .lt          (lt_vec[i]),
      .le          (le_vec[i])
    );
  end

  assign lt_ext = {1'b0, lt_vec, 1'b1};
  assign le_ext = {1'b0, le_vec, 1'b1};

  skv_bound_enc #(.N(CAPACITY + 1), .W(CW)) u_lt_enc (
    .onehot (lt_ext[CAPACITY:0] & ~lt_ext[CAPACITY+1:1]),
    .idx    (lt_idx)
  );

  skv_bound_enc #(.N(CAPACITY + 1), .W(CW)) u_le_enc (
    .onehot (le_ext[CAPACITY:0] & ~le_ext[CAPACITY+1:1]),
    .idx    (le_idx)
  );

  assign run_len = le_idx - lt_idx;

  always_comb begin
    rd_bits = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pos_ext == CMPW'(i)) begin
        rd_bits = rd_bits | entries[i];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    mode          = CM_HOLD;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        case (cmd_r.op)
          OP_INSERT: begin
            if (count_r == CW'(CAPACITY)) begin
              out_nxt.status = ST_FULL;
            end else begin
              mode      = CM_INSERT;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_DELETE: begin
            if (pos_ok) begin
              mode      = CM_DELETE;
              count_nxt = count_r - CW'(1);
            end else begin
              out_nxt.status = ST_BADPOS;
            end
          end
          OP_GET: begin
            if (pos_ok) begin
              out_nxt.key_out   = rd_bits[63:32];
              out_nxt.value_out = rd_bits[31:0];
            end else begin
              out_nxt.status = ST_BADPOS;
            end
          end
          OP_SET: begin
            if (pos_ok) begin
              mode          = CM_DELETE;
              count_nxt     = count_r - CW'(1);
              state_nxt     = S_INS;
              out_valid_nxt = 1'b0;
            end else begin
              out_nxt.status = ST_BADPOS;
            end
          end
          OP_CONTAINS: begin
            out_nxt.found = le_idx != lt_idx;
          end
          OP_INDEX: begin
            out_nxt.found = le_idx != lt_idx;
            if (le_idx != lt_idx) begin
              out_nxt.first_match_res = (lt_idx > CW'(255)) ? 8'd255 : 8'(lt_idx);
              out_nxt.match_count     = (run_len > CW'(511)) ? 9'd511 : 9'(run_len);
            end
          end
          default: begin
            out_nxt.status = ST_OK;
          end
        endcase
      end
      S_INS: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        mode          = CM_INSERT;
        count_nxt     = count_r + CW'(1);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_nxt.entry_total = (count_nxt > CW'(511)) ? 9'd511 : 9'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (start && state_r == S_IDLE) begin
      cmd_r <= in_item;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while cell row busy");

  a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_FULL |-> count_r == CW'(CAPACITY) && $stable(count_r))
    else $error("full insert changed the list");
`endif

endmodule

// ===== src/skv_cell.sv =====
// One storage cell of the sorted list: holds one entry, compares it with
// the search key and shifts towards either neighbour. Depends on skv_pkg.
`timescale 1ns / 1ps

module skv_cell (
  input  logic                  clk,
  input  skv_pkg::skv_cell_ctl_t ctl,
  input  logic signed [31:0]    cmp_key,
  input  skv_pkg::skv_entry_t   new_entry,
  input  skv_pkg::skv_entry_t   left_entry,
  input  skv_pkg::skv_entry_t   right_entry,
  input  logic                  p_left,
  output skv_pkg::skv_entry_t   entry,
  output logic                  p,
  output logic                  lt,
  output logic                  le
);
  import skv_pkg::*;

  skv_entry_t entry_r;
  skv_entry_t entry_nxt;

  always_comb begin
    lt = ctl.vld && (entry_r.key < cmp_key);
    le = ctl.vld && (entry_r.key <= cmp_key);
    p  = (ctl.vld && (entry_r.key >= cmp_key)) || ctl.at_end;
  end

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.mode)
      CM_INSERT: begin
        if (p) begin
          entry_nxt = p_left ? left_entry : new_entry;
        end
      end
      CM_DELETE: begin
        if (ctl.from_pos) begin
          entry_nxt = right_entry;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== src/skv_bound_enc.sv =====
// One-hot to binary encoder for the boundary position in the cell row.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module skv_bound_enc #(
  parameter int N = 257,
  parameter int W = 9
) (
  input  logic [N-1:0] onehot,
  output logic [W-1:0] idx
);

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) begin
        idx = idx | W'(i);
      end
    end
  end

endmodule

// ===== sim/skv_list_checker.sv =====
// Scoreboard for the sorted key/value list unit: keeps its own ordered copy of
// the list, works out the result of every accepted item and compares results.
// Depends on skv_pkg.
`timescale 1ns / 1ps

module skv_list_checker
  import skv_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  skv_in_t  in_item,
  input  logic     out_valid,
  input  skv_out_t out_item,
  output int       fail_count,
  output int       checked,
  output int       full_hits,
  output int       badpos_hits,
  output int       list_len,
  output int       pending
);

  skv_entry_t slots [CAPACITY];
  int         fill;
  skv_out_t   awaited [$];

  task automatic place_pair(input skv_entry_t e);
    int at;
    at = fill;
    for (int i = fill - 1; i >= 0; i--)
      if ($signed(slots[i].key) >= $signed(e.key)) at = i;
    for (int i = fill; i > at; i--) slots[i] = slots[i - 1];
    slots[at] = e;
    fill++;
  endtask

  task automatic remove_at(input int p);
    for (int i = p; i < fill - 1; i++) slots[i] = slots[i + 1];
    fill--;
  endtask

  task automatic apply_item(input skv_in_t it, output skv_out_t r);
    skv_entry_t e;
    r = '0;
    e.key = it.key;
    e.value = it.value;
    case (it.op)
      OP_INSERT: begin
        if (fill >= CAPACITY) r.status = ST_FULL;
        else place_pair(e);
      end
      OP_DELETE: begin
        if (it.pos < fill) remove_at(it.pos);
        else r.status = ST_BADPOS;
      end
      OP_GET: begin
        if (it.pos < fill) begin
          r.key_out = slots[it.pos].key;
          r.value_out = slots[it.pos].value;
        end else begin
          r.status = ST_BADPOS;
        end
      end
      OP_SET: begin
        if (it.pos < fill) begin
          remove_at(it.pos);
          place_pair(e);
        end else begin
          r.status = ST_BADPOS;
        end
      end
      OP_CONTAINS, OP_INDEX: begin
        for (int i = 0; i < fill; i++) begin
          if (slots[i].key == it.key) begin
            if (!r.found) r.first_match_res = 8'(i);
            r.found = 1'b1;
            r.match_count = r.match_count + 9'd1;
          end
        end
        if (it.op == OP_CONTAINS) begin
          r.first_match_res = '0;
          r.match_count = '0;
        end
      end
      default: ;
    endcase
    r.entry_total = 9'(fill);
  endtask

  always @(posedge clk) begin : watch
    skv_out_t want;
    if (!rst_n) begin
      fill = 0;
      awaited.delete();
      fail_count = 0;
      checked = 0;
      full_hits = 0;
      badpos_hits = 0;
    end else begin
      if (out_valid === 1'b1) begin
        if (awaited.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no item outstanding: st=%0d total=%0d",
                     $realtime, out_item.status, out_item.entry_total);
        end else begin
          want = awaited.pop_front();
          checked++;
          if (out_item !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch, exp st=%0d k=%0d v=%0d f=%0b first=%0d n=%0d tot=%0d",
                       $realtime, want.status, want.key_out, want.value_out, want.found,
                       want.first_match_res, want.match_count, want.entry_total);
              $display("             got st=%0d k=%0d v=%0d f=%0b first=%0d n=%0d tot=%0d",
                       out_item.status, out_item.key_out, out_item.value_out,
                       out_item.found, out_item.first_match_res, out_item.match_count,
                       out_item.entry_total);
            end
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        apply_item(in_item, want);
        if (want.status == ST_FULL) full_hits++;
        if (want.status == ST_BADPOS) badpos_hits++;
        awaited.push_back(want);
      end
    end
    list_len = fill;
    pending = awaited.size();
  end

endmodule

// ===== sim/tb.sv =====
// Top of the sorted key/value list testbench: clock, reset and item stimulus,
// with the checker beside the unit and the final verdict.
// Depends on skv_pkg, sorted_key_value_list_unit and skv_list_checker.
`timescale 1ns / 1ps

module tb;
  import skv_pkg::*;

  localparam logic [2:0]         OP_SPARE    = 3'd7;
  localparam logic signed [31:0] KEY_MIN     = 32'sh80000000;
  localparam logic signed [31:0] KEY_MAX     = 32'sh7fffffff;
  localparam int                 CYCLE_LIMIT = 200000;
  localparam int                 SETTLE      = 8;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  logic     out_valid;
  skv_in_t  in_item;
  skv_out_t out_item;

  int fail_count, checked, full_hits, badpos_hits, list_len, pending;
  int sent;
  skv_in_t directed [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_key_value_list_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  skv_list_checker list_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .checked    (checked),
    .full_hits  (full_hits),
    .badpos_hits(badpos_hits),
    .list_len   (list_len),
    .pending    (pending)
  );

  function automatic skv_in_t item_of(logic [2:0] op, logic signed [31:0] key,
                                      logic signed [31:0] value, logic [7:0] pos);
    skv_in_t it;
    it.op = op;
    it.key = key;
    it.value = value;
    it.pos = pos;
    return it;
  endfunction

  // mostly a small pool so that equal keys pile up
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(7))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return int'($urandom_range(15)) - 8;
    endcase
  endfunction

  function automatic logic [7:0] pick_pos();
    if (list_len > 0 && $urandom_range(9) < 8) return 8'($urandom_range(list_len - 1));
    return 8'($urandom_range(255));
  endfunction

  function automatic skv_in_t random_item(int ins_w, int del_w);
    int r;
    logic [2:0] op;
    r = $urandom_range(99);
    if (r < ins_w) op = OP_INSERT;
    else if (r < ins_w + del_w) op = OP_DELETE;
    else if (r >= 97) op = OP_SPARE;
    else begin
      case ($urandom_range(4))
        0: op = OP_GET;
        1: op = OP_SET;
        2: op = OP_CONTAINS;
        3: op = OP_INDEX;
        default: op = OP_SIZE;
      endcase
    end
    return item_of(op, pick_key(), $urandom, pick_pos());
  endfunction

  task automatic send(input skv_in_t it, input int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    in_item <= it;
    start <= 1'b1;
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int n, input int idle_pct, input int ins_w, input int del_w);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(63) == 0) drain();
      send(random_item(ins_w, del_w), idle_pct);
    end
    drain();
  endtask

  initial begin
    for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed.push_back(item_of(OP_SIZE, 0, 0, 8'd0));
    directed.push_back(item_of(OP_GET, 0, 0, 8'd0));
    directed.push_back(item_of(OP_DELETE, 0, 0, 8'd0));
    directed.push_back(item_of(OP_SET, 5, 5, 8'd0));
    directed.push_back(item_of(OP_CONTAINS, 0, 0, 8'd0));
    directed.push_back(item_of(OP_INDEX, 0, 0, 8'd0));
    directed.push_back(item_of(OP_INSERT, KEY_MAX, KEY_MAX, 8'hff));
    directed.push_back(item_of(OP_INSERT, KEY_MIN, KEY_MIN, 8'd0));
    directed.push_back(item_of(OP_INSERT, -1, 0, 8'd0));
    directed.push_back(item_of(OP_INSERT, 0, -1, 8'd0));
    directed.push_back(item_of(OP_INSERT, 0, 1, 8'd0));
    directed.push_back(item_of(OP_INSERT, 0, 32'shaaaaaaaa, 8'd0));
    directed.push_back(item_of(OP_INDEX, 0, 0, 8'd0));
    directed.push_back(item_of(OP_CONTAINS, 1, 0, 8'd0));
    directed.push_back(item_of(OP_CONTAINS, -1, 0, 8'd0));
    directed.push_back(item_of(OP_GET, 0, 0, 8'd0));
    directed.push_back(item_of(OP_GET, 0, 0, 8'd5));
    directed.push_back(item_of(OP_GET, 0, 0, 8'd6));
    directed.push_back(item_of(OP_GET, 0, 0, 8'hff));
    directed.push_back(item_of(OP_SET, KEY_MAX, 32'sh55555555, 8'd0));
    directed.push_back(item_of(OP_SPARE, KEY_MIN, KEY_MAX, 8'h80));
    directed.push_back(item_of(OP_INDEX, KEY_MAX, 0, 8'd0));
    directed.push_back(item_of(OP_DELETE, 0, 0, 8'd5));
    directed.push_back(item_of(OP_DELETE, 0, 0, 8'd0));
    directed.push_back(item_of(OP_SIZE, 0, 0, 8'd0));
    foreach (directed[i]) send(directed[i], 0);
    drain();

    run_phase(275, 0, 45, 20);
    run_phase(350, 71, 80, 5);
    run_phase(300, 23, 5, 80);
    run_phase(200, 0, 30, 50);

    repeat (SETTLE) @(negedge clk);
    $display("Sent %0d items across insert, delete, get, set, contains, index and size;",
             sent);
    $display("%0d results checked, %0d inserts refused on a full list, %0d bad positions.",
             checked, full_hits, badpos_hits);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
